// ----- rtl/text_console_writer_assert.svh -----
// Assertion macros shared by the console writer modules.
`ifndef TEXT_CONSOLE_WRITER_ASSERT_SVH
`define TEXT_CONSOLE_WRITER_ASSERT_SVH
// Implication checked on every clock edge outside reset.
`define TCW_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
// Implication whose consequent is checked in the cycle after the antecedent.
`define TCW_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

// ----- rtl/tcw_pkg.sv -----
// Shared types and constants of the text console writer.
package tcw_pkg;

  // Number of cells in the store.
  localparam int CELLS = 4096;

  typedef enum logic [1:0] {
    ACT_PUT   = 2'd0,
    ACT_SETC  = 2'd1,
    ACT_CLEAR = 2'd2,
    ACT_READ  = 2'd3
  } action_e;

  typedef enum logic [1:0] {
    REG_COLS   = 2'd0,
    REG_ROWS   = 2'd1,
    REG_ATTR   = 2'd2,
    REG_CURSOR = 2'd3
  } reg_e;

  localparam logic [7:0] NL_CODE    = 8'd10;
  localparam logic [7:0] SPACE_CODE = 8'd32;

  // Command from the front part to the back part.
  typedef struct packed {
    action_e     action;
    logic [7:0]  char_code;
    logic [8:0]  pos_x;
    logic [8:0]  pos_y;
    logic [11:0] cell_index;
  } cmd_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCROLL_RD,
    ST_SCROLL_WR,
    ST_FILL,
    ST_READ,
    ST_DONE
  } state_e;

endpackage

// ----- rtl/tcw_cmd_queue.sv -----
// Two-entry queue that decouples the accepting side from the executing side.
module tcw_cmd_queue
  import tcw_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  cmd_t cmd_i,
  output logic full_o,
  input  logic pop_i,
  output cmd_t cmd_o,
  output logic empty_o
);
  `include "text_console_writer_assert.svh"

  cmd_t       mem_q [2];
  logic       wr_q, rd_q;
  logic [1:0] cnt_q;
  logic       do_push, do_pop;

  assign full_o  = cnt_q[1];
  assign empty_o = (cnt_q == 2'd0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign cmd_o   = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (do_push) wr_q <= ~wr_q;
      if (do_pop)  rd_q <= ~rd_q;
      cnt_q <= cnt_q + 2'(do_push) - 2'(do_pop);
    end
  end

  `TCW_ASSERT_IMP(a_cnt_range, clk_i, rst_ni, 1'b1, cnt_q != 2'd3)
  `TCW_ASSERT_IMP(a_ptr_match, clk_i, rst_ni, (cnt_q == 2'd0) || (cnt_q == 2'd2), wr_q == rd_q)
  `TCW_ASSERT_NEXT(a_push_fill, clk_i, rst_ni, do_push && !do_pop, !empty_o)
endmodule

// ----- rtl/tcw_exec.sv -----
// Back part: cursor logic, cell store, scroll and clear sweeps, result register.
module tcw_exec
  import tcw_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cmd_valid_i,
  input  cmd_t        cmd_i,
  output logic        cmd_pop_o,
  input  logic [7:0]  cols_i,
  input  logic [5:0]  rows_i,
  input  logic [7:0]  attr_i,
  input  logic        cursor_en_i,
  output logic        empty_o,
  input  logic        pop_i,
  output logic [7:0]  char_echo_o,
  output logic [6:0]  cursor_col_o,
  output logic [4:0]  cursor_row_out_o,
  output logic [11:0] cursor_location_o,
  output logic        cursor_shown_o,
  output logic [15:0] cell_data_o
);
  `include "text_console_writer_assert.svh"

  localparam int AW = $clog2(CELLS);

  state_e      state_q, state_d;
  logic [6:0]  x_q;
  logic [4:0]  y_q;
  logic [12:0] idx_q;
  logic [12:0] lim_q;
  logic [7:0]  echo_q;
  logic        shown_q;
  logic        rdsel_q;
  logic        res_q;
  logic [15:0] rd_q;
  logic [15:0] mem_q [CELLS];
  logic [7:0]  c;
  logic [5:0]  r;
  logic [6:0]  cx;
  logic [4:0]  cy;
  logic [12:0] cur_addr;
  logic [12:0] src_addr;
  logic [12:0] total;
  logic        we;
  logic [12:0] wa;
  logic [15:0] wd;
  logic        re;
  logic [12:0] ra;
  logic        ra_ok;
  logic [6:0]  nx;
  logic [5:0]  ny;
  logic        wrap;
  logic [6:0]  sx;
  logic [4:0]  sy;
  logic        start;

  assign c = (cols_i == 8'd0) ? 8'd1 : (cols_i > 8'd128) ? 8'd128 : cols_i;
  assign r = (rows_i == 6'd0) ? 6'd1 : (rows_i > 6'd32) ? 6'd32 : rows_i;
  assign cx = ({1'b0, x_q} >= c) ? 7'(c - 8'd1) : x_q;
  assign cy = ({1'b0, y_q} >= r) ? 5'(r - 6'd1) : y_q;
  assign cur_addr = 13'(cy * c) + 13'(cx);
  assign total = 13'(c * r);
  assign src_addr = idx_q + 13'(c);

  // Cursor after a put_char, before any scroll.
  always_comb begin
    wrap = 1'b0;
    if (cmd_i.char_code == NL_CODE) begin
      nx   = 7'd0;
      wrap = 1'b1;
    end else if ((8'(cx) + 8'd1) >= c) begin
      nx   = 7'd0;
      wrap = 1'b1;
    end else begin
      nx = cx + 7'd1;
    end
    ny = 6'(cy) + 6'(wrap);
  end

  // Clamp of a signed set_cursor request.
  always_comb begin
    if (cmd_i.pos_x[8]) sx = 7'd0;
    else if ({1'b0, cmd_i.pos_x} >= 10'(c)) sx = 7'(c - 8'd1);
    else sx = cmd_i.pos_x[6:0];
    if (cmd_i.pos_y[8]) sy = 5'd0;
    else if ({1'b0, cmd_i.pos_y} >= 10'(r)) sy = 5'(r - 6'd1);
    else sy = cmd_i.pos_y[4:0];
  end

  assign start = (state_q == ST_IDLE) && cmd_valid_i && !res_q;
  assign cmd_pop_o = start;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (start) begin
          unique case (cmd_i.action)
            ACT_PUT:   state_d = (ny >= r) ? ((r == 6'd1) ? ST_FILL : ST_SCROLL_RD)
                                           : ST_DONE;
            ACT_SETC:  state_d = ST_DONE;
            ACT_CLEAR: state_d = ST_FILL;
            ACT_READ:  state_d = ST_READ;
            default:   state_d = ST_DONE;
          endcase
        end
      end
      ST_SCROLL_RD: state_d = ST_SCROLL_WR;
      ST_SCROLL_WR: state_d = ((idx_q + 13'd1) >= lim_q) ? ST_FILL : ST_SCROLL_RD;
      ST_FILL:      state_d = ((idx_q + 13'd1) >= total) ? ST_DONE : ST_FILL;
      ST_READ:      state_d = ST_DONE;
      ST_DONE:      state_d = ST_IDLE;
      default:      state_d = ST_IDLE;
    endcase
  end

  // Memory port control.
  always_comb begin
    we = 1'b0;
    wa = idx_q;
    wd = {attr_i, SPACE_CODE};
    re = 1'b0;
    ra = src_addr;
    unique case (state_q)
      ST_IDLE: begin
        if (start && (cmd_i.action == ACT_PUT) && (cmd_i.char_code != NL_CODE)) begin
          we = 1'b1;
          wa = cur_addr;
          wd = {attr_i, cmd_i.char_code};
        end
        if (start && (cmd_i.action == ACT_READ)) begin
          re = 1'b1;
          ra = {1'b0, cmd_i.cell_index};
        end
      end
      ST_SCROLL_RD: re = 1'b1;
      ST_SCROLL_WR: begin
        we = 1'b1;
        wd = rd_q;
      end
      ST_FILL: we = 1'b1;
      default: ;
    endcase
  end

  assign ra_ok = ({19'd0, ra} < 32'(CELLS));

  always_ff @(posedge clk_i) begin
    if (we && ({19'd0, wa} < 32'(CELLS))) begin
      mem_q[wa[AW-1:0]] <= wd;
    end
    if (re) begin
      rd_q <= ra_ok ? mem_q[ra[AW-1:0]] : 16'd0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      x_q     <= 7'd0;
      y_q     <= 5'd0;
      idx_q   <= 13'd0;
      lim_q   <= 13'd0;
      echo_q  <= 8'd0;
      shown_q <= 1'b0;
      rdsel_q <= 1'b0;
      res_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == ST_DONE) res_q <= 1'b1;
      else if (pop_i && res_q) res_q <= 1'b0;
      unique case (state_q)
        ST_IDLE: begin
          if (start) begin
            rdsel_q <= (cmd_i.action == ACT_READ);
            idx_q   <= 13'd0;
            lim_q   <= 13'(c * (r - 6'd1));
            if (cmd_i.action == ACT_PUT) begin
              echo_q  <= cmd_i.char_code;
              shown_q <= cursor_en_i;
              x_q     <= nx;
              y_q     <= (ny >= r) ? 5'(r - 6'd1) : ny[4:0];
            end else if (cmd_i.action == ACT_SETC) begin
              echo_q  <= 8'd0;
              shown_q <= cursor_en_i;
              x_q     <= sx;
              y_q     <= sy;
            end else begin
              echo_q  <= 8'd0;
              shown_q <= 1'b0;
            end
          end
        end
        ST_SCROLL_WR: idx_q <= idx_q + 13'd1;
        ST_FILL:      idx_q <= idx_q + 13'd1;
        default: ;
      endcase
    end
  end

  assign empty_o           = !res_q;
  assign char_echo_o       = echo_q;
  assign cursor_col_o      = x_q;
  assign cursor_row_out_o  = y_q;
  assign cursor_location_o = 12'(y_q * c + 13'(x_q));
  assign cursor_shown_o    = shown_q;
  assign cell_data_o       = rdsel_q ? rd_q : 16'd0;

  `TCW_ASSERT_IMP(a_no_start_busy, clk_i, rst_ni, state_q != ST_IDLE, !cmd_pop_o)
  `TCW_ASSERT_NEXT(a_done_res, clk_i, rst_ni, state_q == ST_DONE, res_q)
  `TCW_ASSERT_IMP(a_hold_res, clk_i, rst_ni, res_q, state_q != ST_DONE)
endmodule

// ----- rtl/text_console_writer.sv -----
// Top level of the text console writer: config registers, command queue, executor.
// Results of put_char and set_cursor go from the queue through ST_DONE into the
// result register, read_cell through ST_READ first. A clear fills all cols*rows
// cells in ST_FILL; a scrolling put_char does one read and one write per moved cell.
// Throughput: one item at a time in the executor; two items may wait in its queue.
// Reset: cursor at 0,0 and registers at defaults; the cell store is not cleared.
module text_console_writer
  import tcw_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  output logic        full,
  input  logic [1:0]  action_i,
  input  logic [7:0]  char_code_i,
  input  logic signed [8:0] pos_x_i,
  input  logic signed [8:0] pos_y_i,
  input  logic [11:0] cell_index_i,
  output logic        empty,
  input  logic        pop,
  output logic [7:0]  char_echo_o,
  output logic [6:0]  cursor_col_o,
  output logic [4:0]  cursor_row_out_o,
  output logic [11:0] cursor_location_o,
  output logic        cursor_shown_o,
  output logic [15:0] cell_data_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [7:0]  cfg_data_i
);
  logic [7:0] cols_q;
  logic [5:0] rows_q;
  logic [7:0] attr_q;
  logic       cur_en_q;
  cmd_t       in_cmd, q_cmd;
  logic       q_empty, q_pop;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cols_q   <= 8'd80;
      rows_q   <= 6'd25;
      attr_q   <= 8'd7;
      cur_en_q <= 1'b0;
    end else if (cfg_valid_i) begin
      unique case (reg_e'(cfg_index_i))
        REG_COLS:   cols_q   <= cfg_data_i;
        REG_ROWS:   rows_q   <= cfg_data_i[5:0];
        REG_ATTR:   attr_q   <= cfg_data_i;
        REG_CURSOR: cur_en_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  assign in_cmd = '{action: action_e'(action_i), char_code: char_code_i,
                    pos_x: pos_x_i, pos_y: pos_y_i, cell_index: cell_index_i};

  tcw_cmd_queue u_queue (
    .clk_i, .rst_ni,
    .push_i(push), .cmd_i(in_cmd), .full_o(full),
    .pop_i(q_pop), .cmd_o(q_cmd), .empty_o(q_empty)
  );

  tcw_exec u_exec (
    .clk_i, .rst_ni,
    .cmd_valid_i(!q_empty), .cmd_i(q_cmd), .cmd_pop_o(q_pop),
    .cols_i(cols_q), .rows_i(rows_q), .attr_i(attr_q), .cursor_en_i(cur_en_q),
    .empty_o(empty), .pop_i(pop),
    .char_echo_o, .cursor_col_o, .cursor_row_out_o, .cursor_location_o,
    .cursor_shown_o, .cell_data_o
  );
endmodule
